// ===== src/congestion_window_update_macros.svh =====
// Assertion macros shared by the congestion window update block.
`ifndef CONGESTION_WINDOW_UPDATE_MACROS_SVH
`define CONGESTION_WINDOW_UPDATE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CWU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CWU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/cwu_pkg.sv =====
// Types and constants of the congestion window update block.
package cwu_pkg;

	localparam int WIN_W = 10;
	localparam int THR_W = 11;
	localparam int OPND_W = 14;
	localparam int ACC_W = 19;
	localparam int QUOT_W = 5;
	localparam int CNT_W = 4;

	localparam logic [THR_W-1:0] THRESH_UNBOUNDED = 11'd2047;
	localparam logic [CNT_W-1:0] MUL_STEPS = 4'd9;
	localparam logic [CNT_W-1:0] DIV_STEPS = 4'd14;

	typedef enum logic [1:0] {
		REG_INITIAL_WINDOW      = 2'd0,
		REG_SLOW_START_INCREASE = 2'd1,
		REG_AVOIDANCE_INCREASE  = 2'd2,
		REG_DECREASE_FACTOR     = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	typedef enum logic [1:0] {
		KIND_RESTART = 2'd0,
		KIND_LOSS    = 2'd1,
		KIND_SLOW    = 2'd2,
		KIND_AVOID   = 2'd3
	} kind_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} unit_op_t;

	typedef struct packed {
		logic     start;
		unit_op_t op;
	} unit_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_rsp_t;

endpackage

// ===== src/cwu_shared_unit.sv =====
// Shared add/subtract unit: shift-add multiply and restoring divide, one bit a cycle.
module cwu_shared_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cwu_pkg::unit_req_t                req,
	input  logic [cwu_pkg::OPND_W-1:0]        mcand,
	input  logic [cwu_pkg::OPND_W-1:0]        opnd,
	output cwu_pkg::unit_rsp_t                rsp,
	output logic [cwu_pkg::ACC_W-1:0]         acc,
	output logic [cwu_pkg::QUOT_W-1:0]        quot
);

	logic                              busy_q;
	logic                              done_q;
	cwu_pkg::unit_op_t                 op_q;
	logic [cwu_pkg::CNT_W-1:0]         cnt_q;
	logic [cwu_pkg::ACC_W-1:0]         acc_q;
	logic [cwu_pkg::OPND_W-1:0]        bits_q;
	logic [cwu_pkg::OPND_W-1:0]        y_q;

	logic                              sub;
	logic [cwu_pkg::ACC_W-1:0]         x;
	logic [cwu_pkg::ACC_W-1:0]         y_ext;
	logic [cwu_pkg::ACC_W-1:0]         addend;
	logic [cwu_pkg::ACC_W:0]           sum;
	logic [cwu_pkg::ACC_W-1:0]         acc_next;
	logic                              bit_in;

	always_comb begin
		sub = (op_q == cwu_pkg::OP_DIV);
		x = {acc_q[cwu_pkg::ACC_W-2:0], sub & bits_q[cwu_pkg::OPND_W-1]};
		y_ext = {{(cwu_pkg::ACC_W-cwu_pkg::OPND_W){1'b0}}, y_q};
		if (sub) begin
			addend = ~y_ext;
		end else if (bits_q[cwu_pkg::OPND_W-1]) begin
			addend = y_ext;
		end else begin
			addend = '0;
		end
		sum = {1'b0, x} + {1'b0, addend} + {{cwu_pkg::ACC_W{1'b0}}, sub};
		if (sub && !sum[cwu_pkg::ACC_W]) begin
			acc_next = x;
		end else begin
			acc_next = sum[cwu_pkg::ACC_W-1:0];
		end
		bit_in = sub & sum[cwu_pkg::ACC_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= cwu_pkg::OP_MUL;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q <= req.op;
				cnt_q <= (req.op == cwu_pkg::OP_DIV) ? cwu_pkg::DIV_STEPS : cwu_pkg::MUL_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			bits_q <= opnd;
			y_q <= mcand;
		end else if (busy_q) begin
			acc_q <= acc_next;
			bits_q <= {bits_q[cwu_pkg::OPND_W-2:0], bit_in};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign acc = acc_q;
	assign quot = bits_q[cwu_pkg::QUOT_W-1:0];

endmodule

// ===== src/congestion_window_update.sv =====
// Top level of the congestion window update block.
//
// One input beat per acknowledgement event (restart, loss) on in_valid/in_ready;
// one result beat (window, in_slow_start) per event on out_valid/out_ready.
// Registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write them only while the block is idle.
// Restart and slow-start growth go straight to the finish state; a loss first
// runs 9 multiply steps and avoidance growth 14 restoring divide steps.
// All steps run through one shared add/subtract unit, so one event is in
// flight at a time; in_ready is high only while the sequencer is idle.
// The result sits in an output register, so the next event is taken while
// it waits; a stalled receiver holds the finished update until out_ready.
// Reset sets window 1, threshold unbounded and the register defaults.
`include "congestion_window_update_macros.svh"

module congestion_window_update #(
	parameter int MAX_WINDOW = 1000
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       restart,
	input  logic       loss,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [9:0] window,
	output logic       in_slow_start,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);

	localparam logic [11:0] MAX_W12 = 12'(MAX_WINDOW);

	cwu_pkg::state_t                   state_q;
	cwu_pkg::kind_t                    kind_q;
	logic [cwu_pkg::WIN_W-1:0]         init_q;
	logic [7:0]                        ssi_q;
	logic [7:0]                        ai_q;
	logic [8:0]                        factor_q;
	logic [cwu_pkg::WIN_W-1:0]         cur_w_q;
	logic [cwu_pkg::THR_W-1:0]         thr_q;
	logic                              out_valid_q;
	logic [cwu_pkg::WIN_W-1:0]         window_q;
	logic                              slow_q;

	logic                              in_fire;
	logic                              fin_fire;
	logic                              is_slow;
	cwu_pkg::kind_t                    kind_in;
	cwu_pkg::unit_req_t                req;
	cwu_pkg::unit_rsp_t                rsp;
	logic [cwu_pkg::OPND_W-1:0]        mcand;
	logic [cwu_pkg::OPND_W-1:0]        opnd;
	logic [cwu_pkg::ACC_W-1:0]         acc;
	logic [cwu_pkg::QUOT_W-1:0]        quot;
	logic [cwu_pkg::OPND_W-1:0]        w_x16;
	logic [cwu_pkg::ACC_W:0]           prod_rnd;
	logic [8:0]                        ss_sum;
	logic [11:0]                       raw_w;
	logic [cwu_pkg::WIN_W-1:0]         new_w;
	logic [cwu_pkg::THR_W-1:0]         new_thr;

	function automatic logic [9:0] cap_win(input logic [11:0] v);
		logic [9:0] r;
		if (v == 12'd0) begin
			r = 10'd1;
		end else if (v > MAX_W12) begin
			r = MAX_W12[9:0];
		end else begin
			r = v[9:0];
		end
		return r;
	endfunction

	assign in_ready = (state_q == cwu_pkg::ST_IDLE);
	assign in_fire = in_valid & in_ready;
	assign fin_fire = (state_q == cwu_pkg::ST_FIN) & (!out_valid_q | out_ready);
	assign cfg_ready = 1'b1;

	always_comb begin
		is_slow = ({cur_w_q, 1'b0} <= thr_q);
		priority if (restart) begin
			kind_in = cwu_pkg::KIND_RESTART;
		end else if (loss) begin
			kind_in = cwu_pkg::KIND_LOSS;
		end else if (is_slow) begin
			kind_in = cwu_pkg::KIND_SLOW;
		end else begin
			kind_in = cwu_pkg::KIND_AVOID;
		end
		w_x16 = {cur_w_q, 4'b0};
		req.start = in_fire & ((kind_in == cwu_pkg::KIND_LOSS) |
			(kind_in == cwu_pkg::KIND_AVOID));
		req.op = (kind_in == cwu_pkg::KIND_LOSS) ? cwu_pkg::OP_MUL : cwu_pkg::OP_DIV;
		if (kind_in == cwu_pkg::KIND_LOSS) begin
			mcand = {4'b0, cur_w_q};
			opnd = {factor_q, 5'b0};
		end else begin
			mcand = w_x16;
			opnd = {6'b0, ai_q} + w_x16 - 14'd1;
		end
	end

	cwu_shared_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.mcand  (mcand),
		.opnd   (opnd),
		.rsp    (rsp),
		.acc    (acc),
		.quot   (quot)
	);

	always_comb begin
		prod_rnd = {1'b0, acc} + 20'd255;
		ss_sum = {1'b0, ssi_q} + 9'd15;
		new_thr = thr_q;
		unique case (kind_q)
			cwu_pkg::KIND_RESTART: begin
				raw_w = {2'b0, init_q};
				new_thr = cwu_pkg::THRESH_UNBOUNDED;
			end
			cwu_pkg::KIND_LOSS: begin
				raw_w = prod_rnd[19:8];
				new_thr = {1'b0, cur_w_q};
			end
			cwu_pkg::KIND_SLOW: begin
				raw_w = {2'b0, cur_w_q} + {7'b0, ss_sum[8:4]};
			end
			cwu_pkg::KIND_AVOID: begin
				raw_w = {2'b0, cur_w_q} + {7'b0, quot};
			end
			default: begin
				raw_w = {2'b0, cur_w_q};
			end
		endcase
		new_w = cap_win(raw_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cwu_pkg::ST_IDLE;
			init_q <= 10'd1;
			ssi_q <= 8'd16;
			ai_q <= 8'd16;
			factor_q <= 9'd128;
			cur_w_q <= 10'd1;
			thr_q <= cwu_pkg::THRESH_UNBOUNDED;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cwu_pkg::cfg_reg_t'(cfg_index))
					cwu_pkg::REG_INITIAL_WINDOW:      init_q <= cfg_data;
					cwu_pkg::REG_SLOW_START_INCREASE: ssi_q <= cfg_data[7:0];
					cwu_pkg::REG_AVOIDANCE_INCREASE:  ai_q <= cfg_data[7:0];
					cwu_pkg::REG_DECREASE_FACTOR:     factor_q <= cfg_data[8:0];
					default: ;
				endcase
			end
			unique case (state_q)
				cwu_pkg::ST_IDLE: begin
					if (in_fire) begin
						state_q <= req.start ? cwu_pkg::ST_RUN : cwu_pkg::ST_FIN;
					end
				end
				cwu_pkg::ST_RUN: begin
					if (rsp.done) begin
						state_q <= cwu_pkg::ST_FIN;
					end
				end
				cwu_pkg::ST_FIN: begin
					if (fin_fire) begin
						cur_w_q <= new_w;
						thr_q <= new_thr;
						state_q <= cwu_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= cwu_pkg::ST_IDLE;
				end
			endcase
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= kind_in;
		end
		if (fin_fire) begin
			window_q <= new_w;
			slow_q <= ({new_w, 1'b0} <= new_thr);
		end
	end

	assign out_valid = out_valid_q;
	assign window = window_q;
	assign in_slow_start = slow_q;

	`CWU_ASSERT_NOW(a_window_range, out_valid_q, (window_q != 10'd0) && ({2'b0, window_q} <= MAX_W12), "window out of range")
	`CWU_ASSERT_NOW(a_busy_not_ready, rsp.busy, !in_ready, "input taken while unit busy")
	`CWU_ASSERT_NOW(a_done_in_run, rsp.done, state_q == cwu_pkg::ST_RUN, "unit done outside run state")
	`CWU_ASSERT_NEXT(a_restart_direct, in_fire && restart, state_q == cwu_pkg::ST_FIN, "restart did not finish directly")

endmodule
